/* rtl/bpc_pkg.sv */
// ---------------------------------------------------------------------------
// Balance PID package
// Shared widths, limits, register indexes and types of the balance PID core.
// ---------------------------------------------------------------------------
package bpc_pkg;

	// Fixed point format of angles, errors and the drive.
	localparam int FRAC_BITS = 8;

	// Field and state widths.
	localparam int IN_W      = 17;
	localparam int GAIN_W    = 16;
	localparam int ERR_W     = 19;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int OUT_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD       = 2'd3;

	// Reset values of the configuration registers.
	localparam logic signed [IN_W-1:0] SETPOINT_RST = 17'sd486;
	localparam logic [GAIN_W-1:0]      KP_RST       = 16'd9984;
	localparam logic [GAIN_W-1:0]      KI_RST       = 16'd1690;
	localparam logic [GAIN_W-1:0]      KD_RST       = 16'd15232;

	// Integral clamp and output limit.
	localparam int ISUM_LIM = 1000 << FRAC_BITS;
	localparam int OUT_LIM  = 255 << FRAC_BITS;

	// Product and sum widths. A gain is zero extended by one bit to make it signed.
	localparam int PROD_E_W = ERR_W + GAIN_W + 1;
	localparam int PROD_D_W = DIFF_W + GAIN_W + 1;
	localparam int T_W      = PROD_D_W + 6;
	localparam int X_W      = T_W - FRAC_BITS;

	// The scaled sum x = floor(T / 2^F) saturates when floor(x / 10) leaves the limit.
	localparam longint X_HI = longint'(OUT_LIM) * 10 + 10;
	localparam longint X_LO = -(longint'(OUT_LIM) * 10);
	localparam int     Y_W  = $clog2(X_HI - X_LO);

	// Division by ten through a reciprocal, exact for any dividend below 2^32.
	localparam int                 RECIP_W     = 32;
	localparam logic [RECIP_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;
	localparam int                 Q_W         = Y_W - 3;

	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	// Stage control handed to the error stage.
	typedef struct packed {
		logic advance;
		logic item_valid;
	} bpc_ctl_t;

endpackage

/* rtl/bpc_sample_if.sv */
// ---------------------------------------------------------------------------
// Balance PID sample channel
// Valid/ready channel that carries one tilt angle and one angle offset.
// ---------------------------------------------------------------------------
interface bpc_sample_if import bpc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] tilt_angle;
	logic signed [IN_W-1:0] angle_offset;

	modport source (output valid, output tilt_angle, output angle_offset, input ready);
	modport sink (input valid, input tilt_angle, input angle_offset, output ready);
endinterface

/* rtl/bpc_drive_if.sv */
// ---------------------------------------------------------------------------
// Balance PID drive channel
// Valid/ready channel that carries one motor drive and its saturation flag.
// ---------------------------------------------------------------------------
interface bpc_drive_if import bpc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] motor_drive;
	logic                    drive_saturated;

	modport source (output valid, output motor_drive, output drive_saturated, input ready);
	modport sink (input valid, input motor_drive, input drive_saturated, output ready);
endinterface

/* rtl/balance_pid_with_clamps_core.sv */
// ---------------------------------------------------------------------------
// Balance PID core with integral and output clamps
// Computes one motor drive per tilt sample from a PID law with anti-windup.
// ---------------------------------------------------------------------------
//
//   channel   direction  beat payload                        handshake
//   sample    in         tilt_angle, angle_offset (Q8.8)     valid / ready
//   drive     out        motor_drive (Q8.8), drive_saturated valid / ready
//   config    in         cfg_index, cfg_data                 cfg_we, no wait
//
// A sample beat can be taken in every cycle in which the pipeline moves; its
// drive beat is offered behind seven registers: input, error stage, gain
// products, weighted sum, range check, reciprocal product and output.
// The pipeline moves in lock step and holds, with sample.ready low, only while
// the output register is full and the drive sink is not ready. Reset clears
// the valid bits, the error sum and the previous error and loads the defaults.
//
// Datapath summary: e = setpoint - angle - offset; the error sum is clamped
// to +/-1000 degrees; T = 10 * (Kp*e + Kd*(e - e_prev)) + Ki*sum, and the
// drive is floor(T / (10 * 2^FRAC_BITS)) saturated to +/-255 degrees. The
// error sum and the previous error live in the error stage and are updated
// as each sample leaves the input register, so consecutive samples see each
// other's state without any bubble.
//
module balance_pid_with_clamps_core import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	bpc_sample_if.sink           sample,
	bpc_drive_if.source          drive
);

	// Configuration registers.
	logic signed [IN_W-1:0] setpoint_q;
	logic [GAIN_W-1:0]      gain_p_q;
	logic [GAIN_W-1:0]      gain_i_q;
	logic [GAIN_W-1:0]      gain_d_q;

	// Pipeline valid bits, one per stage, and the output register valid.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_valid_q;
	logic advance;

	// Input register.
	logic signed [IN_W-1:0] angle_s1;
	logic signed [IN_W-1:0] offset_s1;

	err_t                    err_s2;
	err_t                    sum_s2;
	diff_t                   diff_s2;
	logic signed [X_W-1:0]   x_s4;
	logic signed [OUT_W-1:0] drive_s7;
	logic                    sat_s7;
	bpc_ctl_t                err_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SETPOINT_RST;
			gain_p_q   <= KP_RST;
			gain_i_q   <= KI_RST;
			gain_d_q   <= KD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT: setpoint_q <= $signed(cfg_data[IN_W-1:0]);
				REG_KP:       gain_p_q   <= cfg_data[GAIN_W-1:0];
				REG_KI:       gain_i_q   <= cfg_data[GAIN_W-1:0];
				REG_KD:       gain_d_q   <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The pipeline moves whenever the output register is free or being emptied.
	assign advance      = !out_valid_q || drive.ready;
	assign sample.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= sample.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			angle_s1  <= sample.tilt_angle;
			offset_s1 <= sample.angle_offset;
		end
	end

	// Only a real sample may touch the integrator and the previous error.
	assign err_ctl.advance    = advance;
	assign err_ctl.item_valid = v_s1;

	bpc_error u_error (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (err_ctl),
		.setpoint  (setpoint_q),
		.angle_s1  (angle_s1),
		.offset_s1 (offset_s1),
		.err_s2    (err_s2),
		.sum_s2    (sum_s2),
		.diff_s2   (diff_s2)
	);

	bpc_mac u_mac (
		.clk     (clk),
		.advance (advance),
		.gain_p  (gain_p_q),
		.gain_i  (gain_i_q),
		.gain_d  (gain_d_q),
		.err_s2  (err_s2),
		.sum_s2  (sum_s2),
		.diff_s2 (diff_s2),
		.x_s4    (x_s4)
	);

	bpc_scale u_scale (
		.clk      (clk),
		.advance  (advance),
		.x_s4     (x_s4),
		.drive_s7 (drive_s7),
		.sat_s7   (sat_s7)
	);

	assign drive.valid           = out_valid_q;
	assign drive.motor_drive     = drive_s7;
	assign drive.drive_saturated = sat_s7;

endmodule

/* rtl/bpc_error.sv */
// ---------------------------------------------------------------------------
// Balance PID error stage
// Forms the error, updates the clamped error sum and the previous error.
// ---------------------------------------------------------------------------
module bpc_error import bpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bpc_ctl_t               ctl,
	input  logic signed [IN_W-1:0] setpoint,
	input  logic signed [IN_W-1:0] angle_s1,
	input  logic signed [IN_W-1:0] offset_s1,
	output err_t                   err_s2,
	output err_t                   sum_s2,
	output diff_t                  diff_s2
);

	localparam logic signed [ERR_W:0] SUM_HI = (ERR_W+1)'(ISUM_LIM);
	localparam logic signed [ERR_W:0] SUM_LO = -SUM_HI;

	err_t                error_sum_q;
	err_t                last_error_q;
	err_t                err_c;
	err_t                sum_c;
	diff_t               diff_c;
	logic signed [ERR_W:0] sum_raw;

	assign err_c   = ERR_W'(setpoint) - ERR_W'(angle_s1) - ERR_W'(offset_s1);
	assign sum_raw = (ERR_W+1)'(error_sum_q) + (ERR_W+1)'(err_c);
	assign diff_c  = DIFF_W'(err_c) - DIFF_W'(last_error_q);

	// Anti-windup clamp on the running sum.
	always_comb begin
		if (sum_raw > SUM_HI) begin
			sum_c = ERR_W'(SUM_HI);
		end else if (sum_raw < SUM_LO) begin
			sum_c = ERR_W'(SUM_LO);
		end else begin
			sum_c = ERR_W'(sum_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (ctl.advance && ctl.item_valid) begin
			error_sum_q  <= sum_c;
			last_error_q <= err_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			err_s2  <= err_c;
			sum_s2  <= sum_c;
			diff_s2 <= diff_c;
		end
	end

endmodule

/* rtl/bpc_mac.sv */
// ---------------------------------------------------------------------------
// Balance PID multiply-accumulate
// Three gain products, then the weighted sum scaled down by 2^FRAC_BITS.
// ---------------------------------------------------------------------------
module bpc_mac import bpc_pkg::*; (
	input  logic                  clk,
	input  logic                  advance,
	input  logic [GAIN_W-1:0]     gain_p,
	input  logic [GAIN_W-1:0]     gain_i,
	input  logic [GAIN_W-1:0]     gain_d,
	input  err_t                  err_s2,
	input  err_t                  sum_s2,
	input  diff_t                 diff_s2,
	output logic signed [X_W-1:0] x_s4
);

	logic signed [PROD_E_W-1:0] p_c, p_s3;
	logic signed [PROD_E_W-1:0] i_c, i_s3;
	logic signed [PROD_D_W-1:0] d_c, d_s3;
	logic signed [T_W-1:0]      pd_c;
	logic signed [T_W-1:0]      t_c;

	assign p_c = $signed({1'b0, gain_p}) * err_s2;
	assign i_c = $signed({1'b0, gain_i}) * sum_s2;
	assign d_c = $signed({1'b0, gain_d}) * diff_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			p_s3 <= p_c;
			i_s3 <= i_c;
			d_s3 <= d_c;
		end
	end

	// T = 10 * (P + D) + I, times ten as two shifted copies.
	assign pd_c = T_W'(p_s3) + T_W'(d_s3);
	assign t_c  = (pd_c <<< 3) + (pd_c <<< 1) + T_W'(i_s3);

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s4 <= X_W'(t_c >>> FRAC_BITS);
		end
	end

endmodule

/* rtl/bpc_scale.sv */
// ---------------------------------------------------------------------------
// Balance PID output scaling
// Floor division by ten through a reciprocal, with output saturation.
// ---------------------------------------------------------------------------
module bpc_scale import bpc_pkg::*; (
	input  logic                    clk,
	input  logic                    advance,
	input  logic signed [X_W-1:0]   x_s4,
	output logic signed [OUT_W-1:0] drive_s7,
	output logic                    sat_s7
);

	localparam logic signed [X_W-1:0]   XHI     = X_W'(X_HI);
	localparam logic signed [X_W-1:0]   XLO     = X_W'(X_LO);
	localparam logic signed [Q_W:0]     LIM_Q   = (Q_W+1)'(OUT_LIM);
	localparam logic signed [OUT_W-1:0] LIM_OUT = OUT_W'(OUT_LIM);

	logic                       hi_c, lo_c;
	logic [Y_W-1:0]             y_s5;
	logic                       hi_s5, lo_s5;
	logic [Y_W+RECIP_W-1:0]     prod_s6;
	logic                       hi_s6, lo_s6;
	logic [Q_W-1:0]             q_c;
	logic signed [Q_W:0]        dq_c;
	logic signed [OUT_W-1:0]    drive_c;

	// Range check first; inside the range the offset value fits Y_W bits and is
	// a multiple of ten away from x, so floor division stays exact.
	assign hi_c = (x_s4 >= XHI);
	assign lo_c = (x_s4 < XLO);

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s5  <= Y_W'(x_s4 - XLO);
			hi_s5 <= hi_c;
			lo_s5 <= lo_c;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s6 <= (Y_W+RECIP_W)'(y_s5) * (Y_W+RECIP_W)'(RECIP_TEN);
			hi_s6   <= hi_s5;
			lo_s6   <= lo_s5;
		end
	end

	assign q_c  = Q_W'(prod_s6 >> RECIP_SHIFT);
	assign dq_c = $signed({1'b0, q_c}) - LIM_Q;

	always_comb begin
		if (hi_s6) begin
			drive_c = LIM_OUT;
		end else if (lo_s6) begin
			drive_c = -LIM_OUT;
		end else begin
			drive_c = OUT_W'(dq_c);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s7 <= drive_c;
			sat_s7   <= hi_s6 | lo_s6;
		end
	end

endmodule

/* rtl/bpc_checker.sv */
// ---------------------------------------------------------------------------
// Balance PID port checker
// Checks the drive limits and the flow control seen on the core's ports.
// ---------------------------------------------------------------------------
module bpc_checker import bpc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] motor_drive,
	input logic                    drive_saturated
);

	localparam logic signed [OUT_W-1:0] LIM = OUT_W'(OUT_LIM);

	// A drive beat that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("drive beat dropped while stalled");

	// A stalled drive beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(motor_drive) && $stable(drive_saturated))
		else $error("drive payload changed while stalled");

	// The drive never leaves the output limit.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_drive <= LIM) && (motor_drive >= -LIM))
		else $error("motor drive outside the limit");

	// A saturated beat sits exactly on one of the two limits.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_saturated |-> (motor_drive == LIM) || (motor_drive == -LIM))
		else $error("saturated drive not at the limit");

	// With the output register empty the core always takes a sample.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("sample refused with empty output");

endmodule

bind balance_pid_with_clamps_core bpc_checker u_bpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (sample.ready),
	.out_valid       (drive.valid),
	.out_ready       (drive.ready),
	.motor_drive     (drive.motor_drive),
	.drive_saturated (drive.drive_saturated)
);

/* sim/balance_pid_with_clamps_core_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Balance PID drive checker
// Watches the sample, drive and configuration ports of the balance PID core,
// predicts every drive beat from its own copy of the controller state and
// compares the beats that leave the core in order.
// ---------------------------------------------------------------------------
module bpc_drive_checker import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	bpc_sample_if                sample,
	bpc_drive_if                 drive,
	output int                   mismatch_cnt,
	output int                   outstanding
);

	typedef struct packed {
		logic signed [OUT_W-1:0] level;
		logic                    clipped;
	} drive_beat_t;

	// Shadow of the configuration and of the controller state.
	longint setpoint;
	longint kp;
	longint ki;
	longint kd;
	longint err_acc;
	longint prev_err;

	drive_beat_t drive_q[$];
	int          beat_no;

	task automatic report_mismatch(input string msg);
		$display("[%0t] drive beat %0d: %s", $realtime, beat_no, msg);
		mismatch_cnt++;
	endtask

	// One controller step: updates the shadow state and returns the drive.
	function automatic drive_beat_t pid_drive(input logic signed [IN_W-1:0] angle,
	                                          input logic signed [IN_W-1:0] offset);
		longint      err;
		longint      acc;
		longint      total;
		longint      divisor;
		longint      q;
		drive_beat_t res;
		err = setpoint - longint'(angle) - longint'(offset);
		acc = err_acc + err;
		if (acc > ISUM_LIM)
			acc = ISUM_LIM;
		if (acc < -ISUM_LIM)
			acc = -ISUM_LIM;
		total   = 10 * (kp * err + kd * (err - prev_err)) + ki * acc;
		divisor = longint'(10) << FRAC_BITS;
		q       = total / divisor;
		// Division truncates toward zero; the drive rounds toward minus infinity.
		if ((total % divisor) != 0 && total < 0)
			q = q - 1;
		res.clipped = 1'b0;
		if (q > OUT_LIM) begin
			q           = OUT_LIM;
			res.clipped = 1'b1;
		end
		if (q < -OUT_LIM) begin
			q           = -OUT_LIM;
			res.clipped = 1'b1;
		end
		res.level = q[OUT_W-1:0];
		err_acc   = acc;
		prev_err  = err;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_beat_t want;
		if (!arst_n) begin
			setpoint = longint'(SETPOINT_RST);
			kp       = longint'(KP_RST);
			ki       = longint'(KI_RST);
			kd       = longint'(KD_RST);
			err_acc  = 0;
			prev_err = 0;
			beat_no  = 0;
			drive_q.delete();
			outstanding  = 0;
			mismatch_cnt = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SETPOINT: setpoint = longint'($signed(cfg_data[IN_W-1:0]));
					REG_KP:       kp = longint'(cfg_data[GAIN_W-1:0]);
					REG_KI:       ki = longint'(cfg_data[GAIN_W-1:0]);
					REG_KD:       kd = longint'(cfg_data[GAIN_W-1:0]);
					default: ;
				endcase
			end
			if (sample.valid && sample.ready)
				drive_q.push_back(pid_drive(sample.tilt_angle, sample.angle_offset));
			if (drive.valid && drive.ready) begin
				if (drive_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat, drive %0d sat %0b",
						drive.motor_drive, drive.drive_saturated));
				end else begin
					want = drive_q.pop_front();
					if (drive.motor_drive !== want.level)
						report_mismatch($sformatf("motor_drive %0d, expected %0d",
							drive.motor_drive, want.level));
					if (drive.drive_saturated !== want.clipped)
						report_mismatch($sformatf("drive_saturated %0b, expected %0b",
							drive.drive_saturated, want.clipped));
				end
				beat_no++;
			end
			outstanding = drive_q.size();
		end
	end

endmodule

/* sim/balance_pid_with_clamps_core_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Balance PID core testbench
// Drives tilt samples and configuration writes into the balance PID core and
// lets a separate checker predict and compare every drive beat, under random
// idling on both channels, long drive stalls and a full drain mid-run.
// ---------------------------------------------------------------------------
module balance_pid_with_clamps_core_tb import bpc_pkg::*; ();

	localparam int     CLK_PERIOD   = 4;
	localparam int     RESET_CYCLES = 11;
	// The pipeline is seven beats deep; this covers it with margin.
	localparam int     SETTLE_CYCLES = 16;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     PHASES        = 6;
	localparam int     PHASE_ITEMS   = 242;
	// Far beyond the slowest correct run, with both stalls, the drains and
	// one side idling most of the time, so only a hang reaches it.
	localparam longint TIMEOUT_NS    = 1_600_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SETPOINT;
	logic [CFG_W-1:0]     cfg_data = '0;

	int mismatch_cnt;
	int outstanding;

	// Idle rates in percent, changed by the stimulus as the run goes on.
	int unsigned send_idle_pct = 21;
	int unsigned recv_idle_pct = 79;
	// Bumped by the stimulus; the drive side answers each bump with a long stall.
	int          hold_req_cnt = 0;
	// Setpoint the core holds now; random angles are centered on it.
	int          cur_setpoint = int'(SETPOINT_RST);

	bpc_sample_if smp ();
	bpc_drive_if  drv ();

	balance_pid_with_clamps_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (smp),
		.drive     (drv)
	);

	bpc_drive_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (smp),
		.drive        (drv),
		.mismatch_cnt (mismatch_cnt),
		.outstanding  (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Everything below drives at the falling edge and samples at the rising
	// edge, so the core sees stable inputs and the checker sees settled beats.

	// Offers one sample beat and returns at the falling edge after the
	// handshake. Random idle cycles go in front of the beat, so gaps land on
	// every phase of the pipeline. Entered and left at a falling edge.
	task automatic send_sample(input logic signed [IN_W-1:0] angle,
	                           input logic signed [IN_W-1:0] offset);
		while ($urandom_range(99) < send_idle_pct) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid        <= 1'b1;
		smp.tilt_angle   <= angle;
		smp.angle_offset <= offset;
		@(posedge clk);
		while (!smp.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering samples and waits until every predicted drive beat has
	// left the core. The core is idle afterwards, so registers may be written.
	task automatic drain_drive;
		smp.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Writes all four registers on consecutive cycles. Gains carry a random
	// top data bit that the core must ignore.
	task automatic load_config(input int setpoint, input int unsigned kp,
	                           input int unsigned ki, input int unsigned kd);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SETPOINT;
		cfg_data  <= setpoint[CFG_W-1:0];
		@(negedge clk);
		cfg_index <= REG_KP;
		cfg_data  <= {1'($urandom_range(1)), kp[GAIN_W-1:0]};
		@(negedge clk);
		cfg_index <= REG_KI;
		cfg_data  <= {1'($urandom_range(1)), ki[GAIN_W-1:0]};
		@(negedge clk);
		cfg_index <= REG_KD;
		cfg_data  <= {1'($urandom_range(1)), kd[GAIN_W-1:0]};
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_setpoint = int'($signed(setpoint[IN_W-1:0]));
		@(negedge clk);
	endtask

	// Random sample. Most beats sit near the setpoint so the drive stays
	// inside its limit and the integral wanders; the rest reach the range
	// edges and beyond, where the clamps take over.
	task automatic pick_sample(output logic signed [IN_W-1:0] angle,
	                           output logic signed [IN_W-1:0] offset);
		int unsigned mix;
		int          a;
		int          o;
		mix = $urandom_range(99);
		if (mix < 55) begin
			a = cur_setpoint + int'($urandom_range(2047)) - 1024;
			o = int'($urandom_range(511)) - 256;
		end else if (mix < 80) begin
			a = int'($urandom_range(92160)) - 46080;
			o = int'($urandom_range(8191)) - 4096;
		end else if (mix < 92) begin
			a = int'($urandom_range(92160)) - 46080;
			o = int'($urandom_range(92160)) - 46080;
		end else begin
			a = int'($urandom);
			o = int'($urandom);
		end
		angle  = a[IN_W-1:0];
		offset = o[IN_W-1:0];
	endtask

	// Drive side: random ready, with one long counted stall per request.
	initial begin
		int holds_done;
		holds_done = 0;
		drv.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req_cnt != holds_done) begin
				drv.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				holds_done++;
			end
			drv.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Hang guard.
	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic signed [IN_W-1:0] angle;
		logic signed [IN_W-1:0] offset;
		smp.valid        = 1'b0;
		smp.tilt_angle   = '0;
		smp.angle_offset = '0;
		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats under the reset configuration (setpoint 486).
		// Zero error, then a one-LSB negative error that must floor down.
		send_sample(17'sd486, 17'sd0);
		send_sample(17'sd487, 17'sd0);
		send_sample(17'sd0, 17'sd0);
		// Range edges: large errors of both signs saturate the drive.
		send_sample(17'sd46080, 17'sd46080);
		send_sample(-17'sd46080, -17'sd46080);
		// Beyond the stated range: the biggest positive error, twice, pins
		// the integral at its upper clamp.
		send_sample(-17'sd65536, -17'sd65536);
		send_sample(-17'sd65536, -17'sd65536);
		// The biggest negative error, with a large derivative swing first,
		// then repeated, which swings the integral well below zero.
		send_sample(17'sd65535, 17'sd65535);
		send_sample(17'sd65535, 17'sd65535);
		send_sample(17'sd65535, 17'sd65535);
		// Zero error: after the derivative kick, only the integral drives the output.
		send_sample(17'sd486, 17'sd0);
		send_sample(17'sd486, 17'sd0);
		// Alternating bit patterns on both fields.
		send_sample(17'h0AAAA, 17'h15555);
		send_sample(17'h15555, 17'h0AAAA);
		// Pull the integral back toward zero and come to rest.
		send_sample(-17'sd46080, 17'sd0);
		send_sample(-17'sd46080, 17'sd0);
		send_sample(-17'sd46080, 17'sd0);
		send_sample(17'sd486, 17'sd0);
		send_sample(17'sd400, 17'sd100);
		drain_drive();

		// Random phases, each under its own configuration. The first two
		// phases idle the sender lightly and the receiver heavily, the next
		// two the other way round, the last two not at all.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: ;  // reset configuration
				1: load_config(0, 65535, 65535, 65535);
				2: load_config(-46080, 0, 0, 0);
				3: load_config(46080, $urandom_range(20000), $urandom_range(4000),
				               $urandom_range(30000));
				4: load_config(int'(17'h0FFFF), $urandom, $urandom, $urandom);
				default: load_config(int'(17'h10000), $urandom_range(12000),
				                     $urandom_range(3000), $urandom_range(20000));
			endcase
			if (phase == 2) begin
				send_idle_pct = 79;
				recv_idle_pct = 21;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// A long drive stall while samples keep coming fills the
				// pipeline and must push back on the sample channel.
				if ((phase == 0 || phase == 4) && n == 100)
					hold_req_cnt++;
				// A pause of the sender until every drive beat has come out.
				if (phase == 3 && n == 120)
					drain_drive();
				pick_sample(angle, offset);
				send_sample(angle, offset);
			end
			drain_drive();
		end

		repeat (SETTLE_CYCLES)
			@(negedge clk);
		if (mismatch_cnt == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/bpc_pkg.sv
rtl/bpc_sample_if.sv
rtl/bpc_drive_if.sv
rtl/bpc_error.sv
rtl/bpc_mac.sv
rtl/bpc_scale.sv
rtl/balance_pid_with_clamps_core.sv
rtl/bpc_checker.sv
sim/balance_pid_with_clamps_core_checker.sv
sim/balance_pid_with_clamps_core_tb.sv
